[rtl/core/i2cm_pkg.sv]
// Shared types and constants for the two-bus I2C master bit engine.
// No dependencies; the files that use it refer to it by scoped names.
`default_nettype none

package i2cm_pkg;

  // Command codes carried in the func field of an input item
  localparam logic [2:0] FUNC_TICK    = 3'd0;
  localparam logic [2:0] FUNC_START   = 3'd1;
  localparam logic [2:0] FUNC_STOP    = 3'd2;
  localparam logic [2:0] FUNC_RESTART = 3'd3;
  localparam logic [2:0] FUNC_WRITE   = 3'd4;
  localparam logic [2:0] FUNC_READ    = 3'd5;

  // Delay unit register
  localparam int unsigned  HalfBitW       = 16;
  localparam logic [15:0]  HALF_BIT_RESET = 16'd100;

  // Wait counter holds up to four delay units minus one
  localparam int unsigned  WaitW = HalfBitW + 2;

  // Bits per byte on the wire
  localparam logic [3:0]   BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [2:0] func;
    logic       bus_sel;
    logic [7:0] tx_byte;
    logic       last_read;
    logic       scl_line0;
    logic       sda_line0;
    logic       scl_line1;
    logic       sda_line1;
  } in_item_t;

  typedef struct packed {
    logic       scl0_low;
    logic       sda0_low;
    logic       scl1_low;
    logic       sda1_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_received;
    logic [1:0] frame_error_count;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/core/i2cm_if.sv]
// Channel interfaces of the I2C master bit engine: input items, result
// items and the delay unit write channel. Depends on nothing.
`default_nettype none

interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic       bus_sel;
  logic [7:0] tx_byte;
  logic       last_read;
  logic       scl_line0;
  logic       sda_line0;
  logic       scl_line1;
  logic       sda_line1;

  modport source (output valid, func, bus_sel, tx_byte, last_read,
                  scl_line0, sda_line0, scl_line1, sda_line1, input ready);
  modport sink   (input valid, func, bus_sel, tx_byte, last_read,
                  scl_line0, sda_line0, scl_line1, sda_line1, output ready);
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl0_low;
  logic       sda0_low;
  logic       scl1_low;
  logic       sda1_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_received;
  logic [1:0] frame_error_count;

  modport source (output valid, scl0_low, sda0_low, scl1_low, sda1_low, busy_res,
                  done_res, rx_byte, ack_received, frame_error_count, input ready);
  modport sink   (input valid, scl0_low, sda0_low, scl1_low, sda1_low, busy_res,
                  done_res, rx_byte, ack_received, frame_error_count, output ready);
endinterface

interface i2cm_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] wdata;

  modport source (output valid, wdata, input ready);
  modport sink   (input valid, wdata, output ready);
endinterface

`default_nettype wire

[rtl/core/i2cm_in_reg.sv]
// Input register stage: holds one accepted item until the sequencer takes it.
// Depends on i2cm_pkg.
`default_nettype none

module i2cm_in_reg (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  i2cm_pkg::in_item_t in_item_i,
  output logic               s1_valid_o,
  input  wire                s1_ready_i,
  output i2cm_pkg::in_item_t s1_item_o
);

  logic               valid_q;
  i2cm_pkg::in_item_t item_q;

  // Free when empty or when the held item moves on this cycle
  assign in_ready_o = !valid_q || s1_ready_i;
  assign s1_valid_o = valid_q;
  assign s1_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/i2cm_seq.sv]
// Bit sequencer: phase state, wait counter, shifter, pin drives and the
// result register. Depends on i2cm_pkg.
`default_nettype none

module i2cm_seq (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_valid_i,
  input  wire  [15:0]         cfg_wdata_i,
  input  wire                 s1_valid_i,
  output logic                s1_ready_o,
  input  i2cm_pkg::in_item_t  s1_item_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output i2cm_pkg::out_item_t out_item_o
);

  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    ST_SDA_LOW  = 5'd1,
    ST_SCL_LOW  = 5'd2,
    SP_SCL_LOW  = 5'd3,
    SP_SDA_LOW  = 5'd4,
    SP_SCL_REL  = 5'd5,
    SP_SDA_REL  = 5'd6,
    SP_SAMPLE   = 5'd7,
    RS_SDA_REL  = 5'd8,
    RS_SCL_REL  = 5'd9,
    RS_SDA_LOW  = 5'd10,
    RS_SCL_LOW  = 5'd11,
    WR_DATA     = 5'd12,
    WR_SCL_REL  = 5'd13,
    WR_SCL_LOW  = 5'd14,
    WA_SDA_REL  = 5'd15,
    WA_SCL_REL  = 5'd16,
    WA_SAMPLE   = 5'd17,
    RD_SDA_REL  = 5'd18,
    RD_SCL_REL  = 5'd19,
    RD_SAMPLE   = 5'd20,
    RA_DRIVE    = 5'd21,
    RA_SCL_REL  = 5'd22,
    RA_SCL_LOW  = 5'd23,
    RA_FINISH   = 5'd24,
    PH_END      = 5'd25
  } phase_e;

  phase_e                      phase_q, phase_d;
  logic [i2cm_pkg::WaitW-1:0]  wait_q, wait_d;
  logic [3:0]                  bit_cnt_q, bit_cnt_d;
  logic [7:0]                  shift_q, shift_d;
  logic                        bus_q, bus_d;
  logic                        nack_q, nack_d;
  logic [3:0]                  drv_q, drv_d;
  logic [7:0]                  rx_q, rx_d;
  logic                        ack_q, ack_d;
  logic [1:0]                  err_q, err_d;
  logic [15:0]                 half_bit_q;
  logic                        done;
  logic                        out_valid_q;
  i2cm_pkg::out_item_t         out_q;
  logic                        take;

  // Result register frees up when empty or being drained
  assign s1_ready_o  = !out_valid_q || out_ready_i;
  assign take        = s1_valid_i && s1_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // One tick: start or count down, then run up to two chained phases
  always_comb begin
    logic        run;
    logic        going;
    logic        dly;
    logic        dly4;
    logic        scl_in;
    logic        sda_in;
    logic [1:0]  scl_idx;
    logic [1:0]  sda_idx;
    logic [15:0] h;
    phase_e      nx;

    phase_d   = phase_q;
    wait_d    = wait_q;
    bit_cnt_d = bit_cnt_q;
    shift_d   = shift_q;
    bus_d     = bus_q;
    nack_d    = nack_q;
    drv_d     = drv_q;
    rx_d      = rx_q;
    ack_d     = ack_q;
    err_d     = err_q;
    done      = 1'b0;
    run       = 1'b0;
    going     = 1'b0;
    dly       = 1'b0;
    dly4      = 1'b0;
    nx        = PH_IDLE;

    if (phase_q == PH_IDLE) begin
      if (s1_item_i.func >= i2cm_pkg::FUNC_START && s1_item_i.func <= i2cm_pkg::FUNC_READ) begin
        bus_d     = s1_item_i.bus_sel;
        bit_cnt_d = 4'd0;
        wait_d    = '0;
        run       = 1'b1;
        case (s1_item_i.func)
          i2cm_pkg::FUNC_START:   phase_d = ST_SDA_LOW;
          i2cm_pkg::FUNC_STOP:    phase_d = SP_SCL_LOW;
          i2cm_pkg::FUNC_RESTART: phase_d = RS_SDA_REL;
          i2cm_pkg::FUNC_WRITE: begin
            phase_d = WR_DATA;
            shift_d = s1_item_i.tx_byte;
          end
          default: begin
            phase_d = RD_SDA_REL;
            shift_d = 8'h00;
            nack_d  = s1_item_i.last_read;
          end
        endcase
      end
    end else if (wait_q != '0) begin
      wait_d = wait_q - 1'b1;
    end else begin
      run = 1'b1;
    end

    scl_idx = {bus_d, 1'b0};
    sda_idx = {bus_d, 1'b1};
    scl_in  = bus_d ? s1_item_i.scl_line1 : s1_item_i.scl_line0;
    sda_in  = bus_d ? s1_item_i.sda_line1 : s1_item_i.sda_line0;
    h       = (half_bit_q == 16'd0) ? 16'd1 : half_bit_q;
    going   = run;

    // Only the write bit loop and the read entry chain a second phase
    for (int k = 0; k < 2; k++) begin
      if (going) begin
        dly  = 1'b0;
        dly4 = 1'b0;
        case (phase_d)
          ST_SDA_LOW: begin drv_d[sda_idx] = 1'b1; nx = ST_SCL_LOW; dly = 1'b1; end
          ST_SCL_LOW: begin drv_d[scl_idx] = 1'b1; nx = PH_END;     dly = 1'b1; end
          SP_SCL_LOW: begin drv_d[scl_idx] = 1'b1; nx = SP_SDA_LOW; dly = 1'b1; end
          SP_SDA_LOW: begin drv_d[sda_idx] = 1'b1; nx = SP_SCL_REL; dly = 1'b1; end
          SP_SCL_REL: begin drv_d[scl_idx] = 1'b0; nx = SP_SDA_REL; dly = 1'b1; end
          SP_SDA_REL: begin drv_d[sda_idx] = 1'b0; nx = SP_SAMPLE;  dly = 1'b1; end
          SP_SAMPLE: begin
            err_d = {1'b0, ~scl_in} + {1'b0, ~sda_in};
            nx    = PH_END;
            dly   = 1'b1;
            dly4  = 1'b1;
          end
          RS_SDA_REL: begin drv_d[sda_idx] = 1'b0; nx = RS_SCL_REL; dly = 1'b1; end
          RS_SCL_REL: begin drv_d[scl_idx] = 1'b0; nx = RS_SDA_LOW; dly = 1'b1; end
          RS_SDA_LOW: begin drv_d[sda_idx] = 1'b1; nx = RS_SCL_LOW; dly = 1'b1; end
          RS_SCL_LOW: begin drv_d[scl_idx] = 1'b1; nx = PH_END;     dly = 1'b1; end
          WR_DATA: begin drv_d[sda_idx] = ~shift_d[7]; nx = WR_SCL_REL; dly = 1'b1; end
          WR_SCL_REL: begin drv_d[scl_idx] = 1'b0; nx = WR_SCL_LOW; dly = 1'b1; end
          WR_SCL_LOW: begin
            drv_d[scl_idx] = 1'b1;
            shift_d        = {shift_d[6:0], 1'b0};
            bit_cnt_d      = bit_cnt_d + 4'd1;
            nx = (bit_cnt_d < i2cm_pkg::BITS_PER_BYTE) ? WR_DATA : WA_SDA_REL;
          end
          WA_SDA_REL: begin drv_d[sda_idx] = 1'b0; nx = WA_SCL_REL; dly = 1'b1; end
          WA_SCL_REL: begin drv_d[scl_idx] = 1'b0; nx = WA_SAMPLE;  dly = 1'b1; end
          WA_SAMPLE: begin
            ack_d          = ~sda_in;
            drv_d[scl_idx] = 1'b1;
            nx             = PH_IDLE;
          end
          RD_SDA_REL: begin drv_d[sda_idx] = 1'b0; nx = RD_SCL_REL; end
          RD_SCL_REL: begin drv_d[scl_idx] = 1'b0; nx = RD_SAMPLE;  dly = 1'b1; end
          RD_SAMPLE: begin
            shift_d        = {shift_d[6:0], sda_in};
            drv_d[scl_idx] = 1'b1;
            bit_cnt_d      = bit_cnt_d + 4'd1;
            nx  = (bit_cnt_d < i2cm_pkg::BITS_PER_BYTE) ? RD_SCL_REL : RA_DRIVE;
            dly = 1'b1;
          end
          RA_DRIVE:   begin drv_d[sda_idx] = ~nack_d; nx = RA_SCL_REL; dly = 1'b1; end
          RA_SCL_REL: begin drv_d[scl_idx] = 1'b0;    nx = RA_SCL_LOW; dly = 1'b1; end
          RA_SCL_LOW: begin drv_d[scl_idx] = 1'b1;    nx = RA_FINISH;  dly = 1'b1; end
          RA_FINISH: begin
            drv_d[sda_idx] = 1'b0;
            rx_d           = shift_d;
            nx             = PH_IDLE;
          end
          default: nx = PH_IDLE;
        endcase
        phase_d = nx;
        if (nx == PH_IDLE) begin
          done  = 1'b1;
          going = 1'b0;
        end else if (dly) begin
          wait_d = dly4 ? ({h, 2'b00} - 1'b1) : ({2'b00, h} - 1'b1);
          going  = 1'b0;
        end
      end
    end
  end

  // Sequencer state and delay unit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      wait_q     <= '0;
      bit_cnt_q  <= 4'd0;
      shift_q    <= 8'h00;
      bus_q      <= 1'b0;
      nack_q     <= 1'b0;
      drv_q      <= 4'h0;
      rx_q       <= 8'h00;
      ack_q      <= 1'b0;
      err_q      <= 2'd0;
      half_bit_q <= i2cm_pkg::HALF_BIT_RESET;
    end else begin
      if (cfg_valid_i) begin
        half_bit_q <= cfg_wdata_i;
      end
      if (take) begin
        phase_q   <= phase_d;
        wait_q    <= wait_d;
        bit_cnt_q <= bit_cnt_d;
        shift_q   <= shift_d;
        bus_q     <= bus_d;
        nack_q    <= nack_d;
        drv_q     <= drv_d;
        rx_q      <= rx_d;
        ack_q     <= ack_d;
        err_q     <= err_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_ready_o) begin
      out_valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q.scl0_low          <= drv_d[0];
      out_q.sda0_low          <= drv_d[1];
      out_q.scl1_low          <= drv_d[2];
      out_q.sda1_low          <= drv_d[3];
      out_q.busy_res          <= (phase_d != PH_IDLE);
      out_q.done_res          <= done;
      out_q.rx_byte           <= rx_d;
      out_q.ack_received      <= ack_d;
      out_q.frame_error_count <= err_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/i2c_master_bit_engine.sv]
// Top level of the two-bus open-drain I2C master bit engine.
// Depends on i2cm_pkg, the channel interfaces, i2cm_in_reg and i2cm_seq.
//
// Usage:
//   in_i   : one item per clock tick of the bit sequencer. func selects
//            tick only, start, stop, restart, write byte or read byte;
//            the item also carries the sampled line levels of both buses.
//            Commands that arrive while a sequence runs are dropped.
//   out_o  : exactly one result item per input item, in order: pin drives
//            of both buses, busy, done pulse, last read byte, write ack
//            and the line error count of the latest stop.
//   cfg_i  : writes the delay unit (ticks per half bit); always ready.
//            Write it only while no sequence runs.
// Path: an accepted item passes the input register, then the result register
// behind the sequencer logic.
// Throughput: one item per cycle while out_o is taken.
// Reset: all lines released, sequencer idle, delay unit 100 ticks.
// Stall: when out_o is not taken the result holds, and in_i.ready drops
// once the input register also holds an item.
`default_nettype none

module i2c_master_bit_engine (
  input  wire         clk_i,
  input  wire         rst_ni,
  i2cm_in_if.sink     in_i,
  i2cm_out_if.source  out_o,
  i2cm_cfg_if.sink    cfg_i
);

  i2cm_pkg::in_item_t  in_item;
  i2cm_pkg::in_item_t  s1_item;
  i2cm_pkg::out_item_t out_item;
  logic                s1_valid;
  logic                s1_ready;

  // Pack the channel fields
  assign in_item.func      = in_i.func;
  assign in_item.bus_sel   = in_i.bus_sel;
  assign in_item.tx_byte   = in_i.tx_byte;
  assign in_item.last_read = in_i.last_read;
  assign in_item.scl_line0 = in_i.scl_line0;
  assign in_item.sda_line0 = in_i.sda_line0;
  assign in_item.scl_line1 = in_i.scl_line1;
  assign in_item.sda_line1 = in_i.sda_line1;

  assign cfg_i.ready = 1'b1;

  i2cm_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_item_i  (in_item),
    .s1_valid_o (s1_valid),
    .s1_ready_i (s1_ready),
    .s1_item_o  (s1_item)
  );

  i2cm_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_wdata_i (cfg_i.wdata),
    .s1_valid_i  (s1_valid),
    .s1_ready_o  (s1_ready),
    .s1_item_i   (s1_item),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_item_o  (out_item)
  );

  // Unpack the result fields
  assign out_o.scl0_low          = out_item.scl0_low;
  assign out_o.sda0_low          = out_item.sda0_low;
  assign out_o.scl1_low          = out_item.scl1_low;
  assign out_o.sda1_low          = out_item.sda1_low;
  assign out_o.busy_res          = out_item.busy_res;
  assign out_o.done_res          = out_item.done_res;
  assign out_o.rx_byte           = out_item.rx_byte;
  assign out_o.ack_received      = out_item.ack_received;
  assign out_o.frame_error_count = out_item.frame_error_count;

endmodule

`default_nettype wire

[rtl/core/i2cm_checker.sv]
// Port-level checks for the I2C master bit engine, bound to its top level.
// Depends on nothing but the top level's ports.
`default_nettype none

module i2cm_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire       out_busy,
  input wire       out_done,
  input wire [1:0] out_err,
  input wire [7:0] out_rx,
  input wire       cfg_valid,
  input wire       cfg_ready
);

  // A finished sequence leaves the engine idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_done |-> !out_busy)
    else $error("done reported while still busy");

  // At most two lines can be found low
  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_err != 2'd3)
    else $error("frame error count out of range");

  // An empty result register never blocks the input
  a_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

  // The delay unit write channel never stalls
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_rx) && $stable(out_err))
    else $error("stalled result changed");

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_busy  (out_o.busy_res),
  .out_done  (out_o.done_res),
  .out_err   (out_o.frame_error_count),
  .out_rx    (out_o.rx_byte),
  .cfg_valid (cfg_i.valid),
  .cfg_ready (cfg_i.ready)
);

`default_nettype wire

[bench/i2cm_checker.sv]
// Scoreboard for the two-bus I2C master bit engine: watches the item, result and
// delay unit channels, predicts one result per accepted item and compares them.
// Depends on i2cm_pkg and the channel interfaces in i2cm_if.sv.
module i2cm_scoreboard (
  input  logic clk_i,
  input  logic rst_ni,
  i2cm_in_if   in_mon,
  i2cm_out_if  out_mon,
  i2cm_cfg_if  cfg_mon,
  output int   fail_count_o,
  output int   pending_o,
  output logic seq_idle_o,
  output int   result_count_o,
  output int   done_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Sequencer phases, in the order the command chains walk through them
  typedef enum logic [5:0] {
    PH_IDLE,
    PH_START_SDA, PH_START_SCL,
    PH_STOP_SCL, PH_STOP_SDA, PH_STOP_SCL_REL, PH_STOP_SDA_REL, PH_STOP_SAMPLE,
    PH_RS_SDA_REL, PH_RS_SCL_REL, PH_RS_SDA, PH_RS_SCL,
    PH_WR_DATA, PH_WR_SCL_REL, PH_WR_SCL,
    PH_WACK_REL, PH_WACK_SCL_REL, PH_WACK_SAMPLE,
    PH_RD_REL, PH_RD_SCL_REL, PH_RD_SAMPLE,
    PH_RACK_DATA, PH_RACK_SCL_REL, PH_RACK_SCL, PH_RACK_END,
    PH_END
  } phase_e;

  // Predicted engine state
  logic [15:0] half_bit;
  phase_e      phase;
  logic [17:0] wait_cnt;
  logic [3:0]  bit_cnt;
  logic [7:0]  shreg;
  logic        bus;
  logic        nack_sel;
  logic [3:0]  pins;      // {sda1, scl1, sda0, scl0}, 1 pulls low
  logic [7:0]  rx_last;
  logic        ack_last;
  logic [1:0]  err_last;

  i2cm_pkg::out_item_t expected_q [$];
  i2cm_pkg::in_item_t  seen_in;
  i2cm_pkg::out_item_t seen_out;
  i2cm_pkg::out_item_t want_out;
  int          mismatches;
  int          results;
  int          dones;

  function automatic void set_pin(logic is_sda, logic low);
    pins[{bus, is_sda}] = low;
  endfunction

  function automatic logic scl_seen(i2cm_pkg::in_item_t it);
    return bus ? it.scl_line1 : it.scl_line0;
  endfunction

  function automatic logic sda_seen(i2cm_pkg::in_item_t it);
    return bus ? it.sda_line1 : it.sda_line0;
  endfunction

  // One phase: acts on the pins, returns its wait in delay units
  function automatic logic [2:0] run_phase(i2cm_pkg::in_item_t it, output phase_e nx);
    logic [2:0] units;
    units = 3'd1;
    nx = PH_IDLE;
    case (phase)
      PH_START_SDA: begin set_pin(1'b1, 1'b1); nx = PH_START_SCL; end
      PH_START_SCL: begin set_pin(1'b0, 1'b1); nx = PH_END; end
      PH_STOP_SCL: begin set_pin(1'b0, 1'b1); nx = PH_STOP_SDA; end
      PH_STOP_SDA: begin set_pin(1'b1, 1'b1); nx = PH_STOP_SCL_REL; end
      PH_STOP_SCL_REL: begin set_pin(1'b0, 1'b0); nx = PH_STOP_SDA_REL; end
      PH_STOP_SDA_REL: begin set_pin(1'b1, 1'b0); nx = PH_STOP_SAMPLE; end
      PH_STOP_SAMPLE: begin
        err_last = {1'b0, ~scl_seen(it)} + {1'b0, ~sda_seen(it)};
        nx = PH_END;
        units = 3'd4;
      end
      PH_RS_SDA_REL: begin set_pin(1'b1, 1'b0); nx = PH_RS_SCL_REL; end
      PH_RS_SCL_REL: begin set_pin(1'b0, 1'b0); nx = PH_RS_SDA; end
      PH_RS_SDA: begin set_pin(1'b1, 1'b1); nx = PH_RS_SCL; end
      PH_RS_SCL: begin set_pin(1'b0, 1'b1); nx = PH_END; end
      PH_WR_DATA: begin set_pin(1'b1, ~shreg[7]); nx = PH_WR_SCL_REL; end
      PH_WR_SCL_REL: begin set_pin(1'b0, 1'b0); nx = PH_WR_SCL; end
      PH_WR_SCL: begin
        set_pin(1'b0, 1'b1);
        shreg = {shreg[6:0], 1'b0};
        bit_cnt = bit_cnt + 4'd1;
        nx = (bit_cnt < i2cm_pkg::BITS_PER_BYTE) ? PH_WR_DATA : PH_WACK_REL;
        units = 3'd0;
      end
      PH_WACK_REL: begin set_pin(1'b1, 1'b0); nx = PH_WACK_SCL_REL; end
      PH_WACK_SCL_REL: begin set_pin(1'b0, 1'b0); nx = PH_WACK_SAMPLE; end
      PH_WACK_SAMPLE: begin
        ack_last = ~sda_seen(it);
        set_pin(1'b0, 1'b1);
        units = 3'd0;
      end
      PH_RD_REL: begin set_pin(1'b1, 1'b0); nx = PH_RD_SCL_REL; units = 3'd0; end
      PH_RD_SCL_REL: begin set_pin(1'b0, 1'b0); nx = PH_RD_SAMPLE; end
      PH_RD_SAMPLE: begin
        shreg = {shreg[6:0], sda_seen(it)};
        set_pin(1'b0, 1'b1);
        bit_cnt = bit_cnt + 4'd1;
        nx = (bit_cnt < i2cm_pkg::BITS_PER_BYTE) ? PH_RD_SCL_REL : PH_RACK_DATA;
      end
      PH_RACK_DATA: begin set_pin(1'b1, ~nack_sel); nx = PH_RACK_SCL_REL; end
      PH_RACK_SCL_REL: begin set_pin(1'b0, 1'b0); nx = PH_RACK_SCL; end
      PH_RACK_SCL: begin set_pin(1'b0, 1'b1); nx = PH_RACK_END; end
      PH_RACK_END: begin
        set_pin(1'b1, 1'b0);
        rx_last = shreg;
        units = 3'd0;
      end
      default: units = 3'd0;   // end marker: the command finishes here
    endcase
    return units;
  endfunction

  // One clock tick of the engine, with an optional command
  function automatic i2cm_pkg::out_item_t predict_tick(i2cm_pkg::in_item_t it);
    i2cm_pkg::out_item_t r;
    phase_e     nx;
    logic [2:0] units;
    logic [15:0] h;
    logic       run;
    logic       done;
    logic       halt;
    int         g;
    run = 1'b0;
    done = 1'b0;
    if (phase == PH_IDLE) begin
      if (it.func >= i2cm_pkg::FUNC_START && it.func <= i2cm_pkg::FUNC_READ) begin
        bus = it.bus_sel;
        bit_cnt = '0;
        wait_cnt = '0;
        run = 1'b1;
        case (it.func)
          i2cm_pkg::FUNC_START:   phase = PH_START_SDA;
          i2cm_pkg::FUNC_STOP:    phase = PH_STOP_SCL;
          i2cm_pkg::FUNC_RESTART: phase = PH_RS_SDA_REL;
          i2cm_pkg::FUNC_WRITE: begin
            phase = PH_WR_DATA;
            shreg = it.tx_byte;
          end
          default: begin
            phase = PH_RD_REL;
            shreg = '0;
            nack_sel = it.last_read;
          end
        endcase
      end
    end else if (wait_cnt != '0) begin
      wait_cnt = wait_cnt - 18'd1;
    end else begin
      run = 1'b1;
    end

    // Zero-wait phases chain on the same tick
    if (run) begin
      halt = 1'b0;
      for (g = 0; g < 8 && !halt; g++) begin
        units = run_phase(it, nx);
        phase = nx;
        if (nx == PH_IDLE) begin
          done = 1'b1;
          halt = 1'b1;
        end else if (units != '0) begin
          h = (half_bit == '0) ? 16'd1 : half_bit;
          wait_cnt = 18'(int'(units) * int'(h) - 1);
          halt = 1'b1;
        end
      end
    end

    r.scl0_low = pins[0];
    r.sda0_low = pins[1];
    r.scl1_low = pins[2];
    r.sda1_low = pins[3];
    r.busy_res = (phase != PH_IDLE);
    r.done_res = done;
    r.rx_byte = rx_last;
    r.ack_received = ack_last;
    r.frame_error_count = err_last;
    return r;
  endfunction

  task automatic compare_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] result %0d %s: expected %0h, got %0h",
                 $realtime, results, field, want, got);
    end
  endtask

  // Predict on every accepted item, compare on every accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_bit = i2cm_pkg::HALF_BIT_RESET;
      phase = PH_IDLE;
      wait_cnt = '0;
      bit_cnt = '0;
      shreg = '0;
      bus = 1'b0;
      nack_sel = 1'b0;
      pins = '0;
      rx_last = '0;
      ack_last = 1'b0;
      err_last = '0;
      expected_q.delete();
      mismatches = 0;
      results = 0;
      dones = 0;
      fail_count_o <= 0;
      pending_o <= 0;
      seq_idle_o <= 1'b1;
      result_count_o <= 0;
      done_count_o <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready)
        half_bit = cfg_mon.wdata;

      if (in_mon.valid && in_mon.ready) begin
        seen_in = '{func: in_mon.func, bus_sel: in_mon.bus_sel, tx_byte: in_mon.tx_byte,
                    last_read: in_mon.last_read, scl_line0: in_mon.scl_line0,
                    sda_line0: in_mon.sda_line0, scl_line1: in_mon.scl_line1,
                    sda_line1: in_mon.sda_line1};
        expected_q.push_back(predict_tick(seen_in));
      end

      if (out_mon.valid && out_mon.ready) begin
        seen_out = '{scl0_low: out_mon.scl0_low, sda0_low: out_mon.sda0_low,
                     scl1_low: out_mon.scl1_low, sda1_low: out_mon.sda1_low,
                     busy_res: out_mon.busy_res, done_res: out_mon.done_res,
                     rx_byte: out_mon.rx_byte, ack_received: out_mon.ack_received,
                     frame_error_count: out_mon.frame_error_count};
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] result item arrived with nothing expected", $realtime);
        end else begin
          want_out = expected_q.pop_front();
          compare_field("scl0_low", want_out.scl0_low, seen_out.scl0_low);
          compare_field("sda0_low", want_out.sda0_low, seen_out.sda0_low);
          compare_field("scl1_low", want_out.scl1_low, seen_out.scl1_low);
          compare_field("sda1_low", want_out.sda1_low, seen_out.sda1_low);
          compare_field("busy_res", want_out.busy_res, seen_out.busy_res);
          compare_field("done_res", want_out.done_res, seen_out.done_res);
          compare_field("rx_byte", want_out.rx_byte, seen_out.rx_byte);
          compare_field("ack_received", want_out.ack_received, seen_out.ack_received);
          compare_field("frame_error_count", want_out.frame_error_count,
                        seen_out.frame_error_count);
          if (want_out.done_res) dones++;
        end
        results++;
      end

      fail_count_o <= mismatches;
      pending_o <= expected_q.size();
      seq_idle_o <= (phase == PH_IDLE);
      result_count_o <= results;
      done_count_o <= dones;
    end
  end

endmodule

[bench/testbench.sv]
// Top of the I2C master bit engine bench: clock, reset, item and delay unit
// stimulus under several idling patterns, and the final verdict.
// Depends on i2cm_pkg, i2cm_if.sv, the engine RTL and i2cm_scoreboard.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Unused func codes, behave as plain ticks
  localparam logic [2:0] FUNC_SPARE6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE7 = 3'd7;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int          ITEMS_PER_MODE = 50;
  localparam int          IdlePct [4] = '{0, 51, 0, 21};
  localparam int          StallPct [4] = '{0, 0, 51, 21};
  localparam logic [15:0] UnitForMode [4] = '{16'd1, 16'd2, 16'd0, 16'd3};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned cycle_count = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          commands_sent = 0;
  int          items_sent = 0;

  int   fail_count;
  int   pending;
  logic seq_idle;
  int   result_count;
  int   done_count;

  i2cm_in_if  in_ch ();
  i2cm_out_if out_ch ();
  i2cm_cfg_if cfg_ch ();

  i2c_master_bit_engine DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  i2cm_scoreboard u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_mon       (cfg_ch),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .seq_idle_o    (seq_idle),
    .result_count_o(result_count),
    .done_count_o  (done_count)
  );

  always #1ns clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Result side back-pressure
  always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= stall_pct);

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("i2c_master_bit_engine: mismatch");
    $finish;
  end

  // lines: -1 for random levels, else {scl0, sda0, scl1, sda1}
  function automatic i2cm_pkg::in_item_t make_item(logic [2:0] f, logic b, logic [7:0] tx,
                                                   logic nack, int lines);
    i2cm_pkg::in_item_t it;
    logic [3:0] lv;
    lv = (lines < 0) ? 4'($urandom) : 4'(lines);
    it.func = f;
    it.bus_sel = b;
    it.tx_byte = tx;
    it.last_read = nack;
    it.scl_line0 = lv[3];
    it.sda_line0 = lv[2];
    it.scl_line1 = lv[1];
    it.sda_line1 = lv[0];
    return it;
  endfunction

  // Tick item; noisy ones sometimes carry a command that a busy engine drops
  function automatic i2cm_pkg::in_item_t line_tick(int lines, logic noisy);
    logic [2:0] f;
    f = i2cm_pkg::FUNC_TICK;
    if (noisy && $urandom_range(3) == 0) f = 3'($urandom);
    else if ($urandom_range(3) == 0) f = $urandom_range(1) ? FUNC_SPARE6 : FUNC_SPARE7;
    return make_item(f, 1'($urandom), 8'($urandom), 1'($urandom), lines);
  endfunction

  // Called at a rising edge; returns at the edge that takes the item
  task automatic send_item(i2cm_pkg::in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= it.func;
    in_ch.bus_sel <= it.bus_sel;
    in_ch.tx_byte <= it.tx_byte;
    in_ch.last_read <= it.last_read;
    in_ch.scl_line0 <= it.scl_line0;
    in_ch.sda_line0 <= it.sda_line0;
    in_ch.scl_line1 <= it.scl_line1;
    in_ch.sda_line1 <= it.sda_line1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Issue one command and tick until the engine is idle again
  task automatic run_cmd(logic [2:0] f, logic b, logic [7:0] tx, logic nack, int lines);
    send_item(make_item(f, b, tx, nack, lines));
    commands_sent++;
    // idle flag lags one item here, so a tick past the end is normal
    do send_item(line_tick(lines, 1'b1)); while (!seq_idle);
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (!seq_idle) begin
      @(posedge clk);
      send_item(line_tick(lines, 1'b0));
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    @(posedge clk);
  endtask

  // Ends at a rising edge with every result in and the engine quiet
  task automatic wait_results_drained();
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_half_bit(logic [15:0] units);
    wait_results_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.wdata <= units;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int target;
    int m;
    in_ch.valid = 1'b0;
    in_ch.func = i2cm_pkg::FUNC_TICK;
    in_ch.bus_sel = 1'b0;
    in_ch.tx_byte = '0;
    in_ch.last_read = 1'b0;
    in_ch.scl_line0 = 1'b1;
    in_ch.sda_line0 = 1'b1;
    in_ch.scl_line1 = 1'b1;
    in_ch.sda_line1 = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.wdata = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: one start on the reset delay unit, then single-tick units
    run_cmd(i2cm_pkg::FUNC_START, 1'b0, 8'h00, 1'b0, -1);
    write_half_bit(16'd1);
    run_cmd(i2cm_pkg::FUNC_STOP, 1'b0, 8'h00, 1'b0, 4'b1111);
    run_cmd(i2cm_pkg::FUNC_WRITE, 1'b1, 8'hA5, 1'b0, 4'b0000);
    run_cmd(i2cm_pkg::FUNC_RESTART, 1'b1, 8'h00, 1'b0, -1);
    run_cmd(i2cm_pkg::FUNC_READ, 1'b1, 8'h00, 1'b1, 4'b1111);
    run_cmd(i2cm_pkg::FUNC_STOP, 1'b1, 8'h00, 1'b0, 4'b0000);
    run_cmd(i2cm_pkg::FUNC_STOP, 1'b0, 8'h00, 1'b0, 4'b1011);
    run_cmd(FUNC_SPARE6, 1'b1, 8'hFF, 1'b1, -1);
    run_cmd(FUNC_SPARE7, 1'b0, 8'hFF, 1'b1, -1);
    run_cmd(i2cm_pkg::FUNC_TICK, 1'b1, 8'hFF, 1'b1, -1);

    // Random commands on random line levels under each idle/stall mix
    for (m = 0; m < 4; m++) begin
      idle_pct = 0;
      stall_pct = 0;
      write_half_bit(UnitForMode[m]);
      idle_pct = IdlePct[m];
      stall_pct = StallPct[m];
      target = items_sent + ITEMS_PER_MODE;
      while (items_sent < target)
        run_cmd(3'($urandom_range(i2cm_pkg::FUNC_START, i2cm_pkg::FUNC_READ)),
                1'($urandom), 8'($urandom), 1'($urandom), -1);
    end

    idle_pct = 0;
    stall_pct = 0;
    wait_results_drained();
    repeat (8) @(posedge clk);

    $display("Checked %0d results from %0d items, %0d command completions, %0d commands,",
             result_count, items_sent, done_count, commands_sent);
    $display("with delay units 100, 1, 2, 0 and 3 under four idle/stall mixes.");
    if (fail_count == 0 && pending == 0)
      $display("i2c_master_bit_engine: match");
    else
      $display("i2c_master_bit_engine: mismatch");
    $finish;
  end

endmodule
